// ===== hw/rtl/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, constants and helpers for the escape-time block.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

   localparam int COORD_W     = 32;
   localparam int STEP_W      = 31;
   localparam int INDEX_W     = 12;
   localparam int COUNT_W     = 16;
   localparam int PROD_W      = 64;
   localparam int FRAC_BITS_DEF = 28;

   typedef enum logic [2:0] {
      CSR_REAL_ORIGIN = 3'd0,
      CSR_IMAG_ORIGIN = 3'd1,
      CSR_REAL_STEP   = 3'd2,
      CSR_IMAG_STEP   = 3'd3,
      CSR_ITER_LIMIT  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] re;
      logic signed [COORD_W-1:0] im;
   } coord_type;

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'({1'b0, {(COORD_W-1){1'b1}}});
      lo = -hi - PROD_W'(1);
      if (v > hi) begin
         return {1'b0, {(COORD_W-1){1'b1}}};
      end else if (v < lo) begin
         return {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         return v[COORD_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mbe_iter.sv =====
// ----------------------------------------------------------------------------
// mbe_iter
// Three-stage iteration ring for z = z^2 + c, shared by up to three pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_iter #(
   parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [mbe_pkg::COUNT_W-1:0]  limit,
   input  wire logic                         ins_valid,
   input  wire mbe_pkg::coord_type           ins_c,
   output logic                              ins_ready,
   output logic                              res_valid,
   output logic [mbe_pkg::COUNT_W-1:0]       res_count,
   input  wire logic                         res_ready
);
   import mbe_pkg::*;

   localparam int  THR_SHIFT = 2 * FRAC_BITS + 2;
   localparam bit  THR_FITS  = (THR_SHIFT < PROD_W);
   localparam logic [PROD_W-1:0] THRESHOLD =
      THR_FITS ? (PROD_W'(1) << (THR_FITS ? THR_SHIFT : 0)) : '0;
   localparam int  TAG_W     = 2;

   // stage a: state at iteration start
   logic                      a_v_ff, a_v_in;
   coord_type                 a_z_ff, a_z_in;
   coord_type                 a_c_ff, a_c_in;
   logic [COUNT_W-1:0]        a_cnt_ff, a_cnt_in;
   logic [TAG_W-1:0]          a_tag_ff, a_tag_in;
   logic                      a_fin_ff, a_fin_in;

   // stage b: products
   logic                      b_v_ff;
   logic signed [PROD_W-1:0]  b_r2_ff, b_i2_ff, b_x_ff;
   coord_type                 b_c_ff;
   logic [COUNT_W-1:0]        b_cnt_ff;
   logic                      b_run_ff;
   logic [TAG_W-1:0]          b_tag_ff;
   logic                      b_fin_ff;

   // stage c: shifted terms and escape flag
   logic                      c_v_ff;
   logic signed [PROD_W-1:0]  c_tr_ff, c_ti_ff;
   coord_type                 c_c_ff;
   logic [COUNT_W-1:0]        c_cnt_ff;
   logic                      c_run_ff;
   logic                      c_esc_ff;
   logic [TAG_W-1:0]          c_tag_ff;
   logic                      c_fin_ff;

   // arrival order tags of the oldest pixel and of the next one in
   logic [TAG_W-1:0]          head_ff, tail_ff;

   logic                      c_done;
   logic                      c_retire;
   logic                      c_recirc;
   logic                      ring_en;
   logic                      a_run;
   logic [PROD_W-1:0]         mag_sum;

   assign a_run     = ({1'b0, a_cnt_ff} + (COUNT_W+1)'(1)) < {1'b0, limit};
   assign c_done    = c_fin_ff || !c_run_ff || c_esc_ff;
   assign c_retire  = c_v_ff && c_done && (c_tag_ff == head_ff);
   assign c_recirc  = c_v_ff && !c_retire;
   assign ring_en   = !(c_retire && !res_ready);
   assign ins_ready = ring_en && !c_recirc;
   assign res_valid = c_retire;
   assign res_count = c_cnt_ff;
   assign mag_sum   = b_r2_ff + b_i2_ff;

   always_comb begin
      a_v_in   = 1'b0;
      a_z_in   = ins_c;
      a_c_in   = ins_c;
      a_cnt_in = '0;
      a_tag_in = tail_ff;
      a_fin_in = 1'b0;
      if (c_recirc) begin
         a_v_in   = 1'b1;
         a_c_in   = c_c_ff;
         a_tag_in = c_tag_ff;
         if (c_done) begin
            // finished early, circles until older pixels have left
            a_fin_in = 1'b1;
            a_cnt_in = c_cnt_ff;
         end else begin
            a_z_in.re = sat32(c_tr_ff + PROD_W'(c_c_ff.re));
            a_z_in.im = sat32(c_ti_ff + PROD_W'(c_c_ff.im));
            a_cnt_in  = c_cnt_ff + COUNT_W'(1);
         end
      end else if (ins_valid) begin
         a_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff  <= 1'b0;
         b_v_ff  <= 1'b0;
         c_v_ff  <= 1'b0;
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         if (ring_en) begin
            a_v_ff <= a_v_in;
            b_v_ff <= a_v_ff;
            c_v_ff <= b_v_ff;
         end
         if (ins_valid && ins_ready) tail_ff <= tail_ff + TAG_W'(1);
         if (res_valid && res_ready) head_ff <= head_ff + TAG_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ring_en) begin
         a_z_ff   <= a_z_in;
         a_c_ff   <= a_c_in;
         a_cnt_ff <= a_cnt_in;
         a_tag_ff <= a_tag_in;
         a_fin_ff <= a_fin_in;

         b_r2_ff  <= PROD_W'(a_z_ff.re) * PROD_W'(a_z_ff.re);
         b_i2_ff  <= PROD_W'(a_z_ff.im) * PROD_W'(a_z_ff.im);
         b_x_ff   <= PROD_W'(a_z_ff.re) * PROD_W'(a_z_ff.im);
         b_c_ff   <= a_c_ff;
         b_cnt_ff <= a_cnt_ff;
         b_run_ff <= a_run;
         b_tag_ff <= a_tag_ff;
         b_fin_ff <= a_fin_ff;

         c_tr_ff  <= (b_r2_ff - b_i2_ff) >>> FRAC_BITS;
         c_ti_ff  <= b_x_ff >>> (FRAC_BITS - 1);
         c_esc_ff <= THR_FITS && (mag_sum > THRESHOLD);
         c_c_ff   <= b_c_ff;
         c_cnt_ff <= b_cnt_ff;
         c_run_ff <= b_run_ff;
         c_tag_ff <= b_tag_ff;
         c_fin_ff <= b_fin_ff;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mandelbrot_escape_time_top.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top
// Escape-time count for one pixel per transfer, signed fixed point.
// ----------------------------------------------------------------------------
// Each pixel's c is formed in the front-end registers f1 and f2, then z = z^2 + c
// is iterated in a three-stage multiply/shift/add ring that holds up to three
// pixels at once, until the pixel escapes or reaches the limit (default 100).
// Results leave in arrival order; a pixel that finishes early keeps circling
// the ring until every older pixel has left, which can add to its latency.
`default_nettype none

module mandelbrot_escape_time_top #(
   parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [2:0]                    csr_index,
   input  wire logic [mbe_pkg::COORD_W-1:0]   csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [mbe_pkg::INDEX_W-1:0]   req_pixel_column,
   input  wire logic [mbe_pkg::INDEX_W-1:0]   req_pixel_row,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [mbe_pkg::COUNT_W-1:0]        rsp_iteration_count
);
   import mbe_pkg::*;

   localparam int SPROD_W = INDEX_W + STEP_W;

   logic signed [COORD_W-1:0] real_origin_ff, imag_origin_ff;
   logic [STEP_W-1:0]         real_step_ff, imag_step_ff;
   logic [COUNT_W-1:0]        limit_ff;

   logic                      f1_v_ff, f2_v_ff;
   logic [SPROD_W-1:0]        f1_pr_ff, f1_pi_ff;
   coord_type                 f2_c_ff;
   logic                      f1_go, f2_go;

   logic                      ins_ready;
   logic                      res_valid, res_ready;
   logic [COUNT_W-1:0]        res_count;

   logic                      rsp_valid_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         real_origin_ff <= -32'sd536870912;
         imag_origin_ff <= -32'sd402653184;
         real_step_ff   <= STEP_W'(786432);
         imag_step_ff   <= STEP_W'(786432);
         limit_ff       <= COUNT_W'(100);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_REAL_ORIGIN: real_origin_ff <= csr_wdata;
            CSR_IMAG_ORIGIN: imag_origin_ff <= csr_wdata;
            CSR_REAL_STEP:   real_step_ff   <= csr_wdata[STEP_W-1:0];
            CSR_IMAG_STEP:   imag_step_ff   <= csr_wdata[STEP_W-1:0];
            CSR_ITER_LIMIT:  limit_ff       <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // coordinate front end
   assign f2_go     = !f2_v_ff || ins_ready;
   assign f1_go     = !f1_v_ff || f2_go;
   assign req_ready = f1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else begin
         if (f1_go) f1_v_ff <= req_valid;
         if (f2_go) f2_v_ff <= f1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f1_go) begin
         f1_pr_ff <= SPROD_W'(req_pixel_column) * SPROD_W'(real_step_ff);
         f1_pi_ff <= SPROD_W'(req_pixel_row) * SPROD_W'(imag_step_ff);
      end
      if (f2_go) begin
         f2_c_ff.re <= sat32(PROD_W'(real_origin_ff) + PROD_W'(f1_pr_ff));
         f2_c_ff.im <= sat32(PROD_W'(imag_origin_ff) + PROD_W'(f1_pi_ff));
      end
   end

   mbe_iter #(
      .FRAC_BITS (FRAC_BITS)
   ) u_iter (
      .clock     (clock),
      .reset     (reset),
      .limit     (limit_ff),
      .ins_valid (f2_v_ff),
      .ins_c     (f2_c_ff),
      .ins_ready (ins_ready),
      .res_valid (res_valid),
      .res_count (res_count),
      .res_ready (res_ready)
   );

   // output register
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_count_ff <= res_count;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iteration_count = rsp_count_ff;

endmodule

`default_nettype wire
